### rtl/irpd_pkg.sv
// Shared types, codes and reset values for the IR pulse-distance decoder.
`default_nettype none
package irpd_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_ACTIVE_LEVEL     = 3'd0;
  localparam logic [2:0] REG_HEADER_MARK_MIN  = 3'd1;
  localparam logic [2:0] REG_HEADER_SPACE_MIN = 3'd2;
  localparam logic [2:0] REG_BIT_MARK_NOMINAL = 3'd3;
  localparam logic [2:0] REG_BIT_MARGIN       = 3'd4;
  localparam logic [2:0] REG_MAX_FRAME_BYTES  = 3'd5;

  // Register reset values
  localparam logic        RST_ACTIVE_LEVEL     = 1'b1;
  localparam logic [14:0] RST_HEADER_MARK_MIN  = 15'd2700;
  localparam logic [14:0] RST_HEADER_SPACE_MIN = 15'd1600;
  localparam logic [13:0] RST_BIT_MARK_NOMINAL = 14'd400;
  localparam logic [13:0] RST_BIT_MARGIN       = 14'd150;
  localparam logic [7:0]  RST_MAX_FRAME_BYTES  = 8'd19;

  // Result event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_BYTE  = 2'd1;
  localparam logic [1:0] EV_FRAME = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  // Symbol kinds, highest priority first
  localparam logic [1:0] SYM_END     = 2'd0;
  localparam logic [1:0] SYM_HEADER  = 2'd1;
  localparam logic [1:0] SYM_INVALID = 2'd2;
  localparam logic [1:0] SYM_DATA    = 2'd3;

  typedef struct packed {
    logic        active_level;
    logic [14:0] header_mark_min;
    logic [14:0] header_space_min;
    logic [13:0] bit_mark_nominal;
    logic [13:0] mark_tolerance;
  } cls_cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       bit_one;
  } sym_t;

endpackage
`default_nettype wire

### rtl/irpd_classify.sv
// Pulse pair classifier: end, header, invalid or data bit.
`default_nettype none
module irpd_classify (
  input  wire  irpd_pkg::cls_cfg_t cfg,
  input  wire                      first_level,
  input  wire  [14:0]              first_duration,
  input  wire  [14:0]              second_duration,
  output irpd_pkg::sym_t           sym
);
  import irpd_pkg::*;

  logic [14:0]        mark;
  logic [14:0]        space;
  logic signed [16:0] lo_bound;
  logic [15:0]        hi_bound;
  logic signed [16:0] mark_s;
  logic               is_header;
  logic               is_invalid;

  always_comb begin
    if (first_level == cfg.active_level) begin
      mark  = first_duration;
      space = second_duration;
    end else begin
      mark  = second_duration;
      space = first_duration;
    end
    // lower bound may go negative when margin exceeds nominal
    lo_bound   = $signed({3'b000, cfg.bit_mark_nominal}) - $signed({3'b000, cfg.mark_tolerance});
    hi_bound   = {2'b00, cfg.bit_mark_nominal} + {2'b00, cfg.mark_tolerance};
    mark_s     = $signed({2'b00, mark});
    is_header  = ((mark > cfg.header_mark_min) && (space < mark)) ||
                 ((space > cfg.header_space_min) && (mark < space));
    is_invalid = (mark_s < lo_bound) || ({1'b0, mark} > hi_bound);

    sym.bit_one = ({1'b0, space} >= {mark, 1'b0});
    if (space == 15'd0) begin
      sym.kind = SYM_END;
    end else if (is_header) begin
      sym.kind = SYM_HEADER;
    end else if (is_invalid) begin
      sym.kind = SYM_INVALID;
    end else begin
      sym.kind = SYM_DATA;
    end
  end

endmodule
`default_nettype wire

### rtl/ir_pulse_distance_frame_decoder_unit.sv
// Top level of the IR pulse-distance frame decoder.
// Usage:
//   Slave stream (s_*) carries one captured pulse pair per item: the line
//   level of the first half and the tick durations of both halves.
//   Master stream (m_*) returns exactly one result item per pulse pair: the event
//   code (nothing, byte done, frame done, error) on m_tuser, with the byte value and
//   index, or the frame length, on m_tdata. The cfg_* port writes one register per
//   cycle; the user must write only while the block is idle, which it does not enforce.
// Throughput and pipeline:
//   One item per cycle sustained while m_tready stays high. A pair is captured in the
//   input register, then classified and applied to the frame state once the result
//   register is free, which also registers its result for m_tvalid. A single
//   compare-and-select pass lies between the input and result registers.
// Reset (rst, synchronous): registers return to their defaults, the frame
//   state clears and both stages empty.
// Stall: while m_tready is low the result holds, the input register holds
//   the next pair, and s_tready drops once both are full.
`default_nettype none
module ir_pulse_distance_frame_decoder_unit (
  input  wire         clk,
  input  wire         rst,
  // pulse pair input
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // first_level[0], first_duration[15:1],
                                 // second_duration[30:16], unused[31]
  // result output
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // byte_value[7:0], byte_index[15:8], frame_length[23:16]
  output logic [1:0]  m_tuser,   // event_res[1:0]
  // configuration
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [14:0] cfg_wdata
);
  import irpd_pkg::*;

  // configuration registers
  cls_cfg_t    cls_cfg;
  logic [7:0]  max_frame_bytes;

  // input stage
  logic        in_valid;
  logic        in_level;
  logic [14:0] in_first;
  logic [14:0] in_second;

  // frame state
  logic [7:0]  shift_byte, shift_byte_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [7:0]  byte_count, byte_count_next;
  logic        frame_open, frame_open_next;

  // result register fields
  logic [1:0]  event_res, event_res_next;
  logic [7:0]  byte_value, byte_value_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [7:0]  frame_length, frame_length_next;

  sym_t        sym;
  logic        out_free;
  logic        fire;

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;
  assign m_tdata  = {frame_length, byte_index, byte_value};
  assign m_tuser  = event_res;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cls_cfg.active_level     <= RST_ACTIVE_LEVEL;
      cls_cfg.header_mark_min  <= RST_HEADER_MARK_MIN;
      cls_cfg.header_space_min <= RST_HEADER_SPACE_MIN;
      cls_cfg.bit_mark_nominal <= RST_BIT_MARK_NOMINAL;
      cls_cfg.mark_tolerance   <= RST_BIT_MARGIN;
      max_frame_bytes          <= RST_MAX_FRAME_BYTES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_LEVEL:     cls_cfg.active_level     <= cfg_wdata[0];
        REG_HEADER_MARK_MIN:  cls_cfg.header_mark_min  <= cfg_wdata;
        REG_HEADER_SPACE_MIN: cls_cfg.header_space_min <= cfg_wdata;
        REG_BIT_MARK_NOMINAL: cls_cfg.bit_mark_nominal <= cfg_wdata[13:0];
        REG_BIT_MARGIN:       cls_cfg.mark_tolerance   <= cfg_wdata[13:0];
        REG_MAX_FRAME_BYTES:  max_frame_bytes          <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Capture the pulse pair; drop it once it has been applied
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_level  <= s_tdata[0];
      in_first  <= s_tdata[15:1];
      in_second <= s_tdata[30:16];
    end
  end

  irpd_classify u_classify (
    .cfg             (cls_cfg),
    .first_level     (in_level),
    .first_duration  (in_first),
    .second_duration (in_second),
    .sym             (sym)
  );

  // Apply the symbol to the frame state and build the result
  always_comb begin
    shift_byte_next   = shift_byte;
    bit_count_next    = bit_count;
    byte_count_next   = byte_count;
    frame_open_next   = frame_open;
    event_res_next    = EV_NONE;
    byte_value_next   = 8'd0;
    byte_index_next   = 8'd0;
    frame_length_next = 8'd0;
    unique case (sym.kind)
      SYM_END: begin
        // clean end only on a byte boundary, even outside a frame
        if (bit_count == 3'd0) begin
          event_res_next    = EV_FRAME;
          frame_length_next = byte_count;
        end else begin
          event_res_next = EV_ERROR;
        end
        bit_count_next  = 3'd0;
        byte_count_next = 8'd0;
        frame_open_next = 1'b0;
      end
      SYM_HEADER: begin
        bit_count_next  = 3'd0;
        byte_count_next = 8'd0;
        frame_open_next = 1'b1;
      end
      SYM_INVALID: begin
        frame_open_next = 1'b0;
        event_res_next  = EV_ERROR;
      end
      default: begin
        // data bit, ignored outside a frame; shift in LSB first
        if (frame_open) begin
          shift_byte_next = {sym.bit_one, shift_byte[7:1]};
          bit_count_next  = bit_count + 3'd1;
          if (bit_count == 3'd7) begin
            if (byte_count < max_frame_bytes) begin
              event_res_next  = EV_BYTE;
              byte_value_next = shift_byte_next;
              byte_index_next = byte_count;
              byte_count_next = byte_count + 8'd1;
            end else begin
              // overflow: close the frame, hold the count
              frame_open_next = 1'b0;
              event_res_next  = EV_ERROR;
            end
          end
        end
      end
    endcase
  end

  // Advance frame state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte <= 8'd0;
      bit_count  <= 3'd0;
      byte_count <= 8'd0;
      frame_open <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (fire) begin
        shift_byte <= shift_byte_next;
        bit_count  <= bit_count_next;
        byte_count <= byte_count_next;
        frame_open <= frame_open_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      event_res    <= event_res_next;
      byte_value   <= byte_value_next;
      byte_index   <= byte_index_next;
      frame_length <= frame_length_next;
    end
  end

endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the IR pulse-distance frame decoder: framed random pulse pairs.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import irpd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_STALL   = 300;
  localparam int DUR_MAX      = 32767;

  typedef struct packed {
    logic        lvl;
    logic [14:0] d_first;
    logic [14:0] d_second;
  } pulse_pair_t;

  typedef struct packed {
    logic [1:0] ev;
    logic [7:0] val;
    logic [7:0] idx;
    logic [7:0] len;
  } decode_result_t;

  // DUT ports; every input starts at a known value
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = REG_ACTIVE_LEVEL;
  logic [14:0] cfg_wdata = '0;

  // Decoder copy: registers and frame state
  logic        c_active;
  logic [14:0] c_hdr_mark;
  logic [14:0] c_hdr_space;
  logic [13:0] c_nominal;
  logic [13:0] c_margin;
  logic [7:0]  c_max_bytes;
  logic [7:0]  shift_reg;
  logic [2:0]  bit_cnt;
  logic [7:0]  byte_cnt;
  logic        frame_open;

  pulse_pair_t    pairs_to_send[$];
  decode_result_t expected_events[$];
  int             pairs_made     = 0;
  int             n_fail         = 0;
  int             cycles         = 0;
  int             send_idle_pct  = 11;
  int             recv_idle_pct  = 69;
  int             rx_stall_req   = 0;
  int             rx_stall_done  = 0;
  int             rx_stall_left  = 0;
  logic           pair_taken     = 1'b0;

  ir_pulse_distance_frame_decoder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // first_level[0], first_duration[15:1], second_duration[30:16]
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // byte_value[7:0], byte_index[15:8], frame_length[23:16]
    .m_tuser   (m_tuser),    // event_res[1:0]
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  // Return registers and frame state to their reset values.
  task automatic clear_decoder();
    c_active    = RST_ACTIVE_LEVEL;
    c_hdr_mark  = RST_HEADER_MARK_MIN;
    c_hdr_space = RST_HEADER_SPACE_MIN;
    c_nominal   = RST_BIT_MARK_NOMINAL;
    c_margin    = RST_BIT_MARGIN;
    c_max_bytes = RST_MAX_FRAME_BYTES;
    shift_reg   = '0;
    bit_cnt     = '0;
    byte_cnt    = '0;
    frame_open  = 1'b0;
  endtask

  task automatic apply_reg(logic [2:0] index, logic [14:0] value);
    case (index)
      REG_ACTIVE_LEVEL:     c_active    = value[0];
      REG_HEADER_MARK_MIN:  c_hdr_mark  = value;
      REG_HEADER_SPACE_MIN: c_hdr_space = value;
      REG_BIT_MARK_NOMINAL: c_nominal   = value[13:0];
      REG_BIT_MARGIN:       c_margin    = value[13:0];
      REG_MAX_FRAME_BYTES:  c_max_bytes = value[7:0];
      default: ;
    endcase
  endtask

  // Classify one pulse pair and advance the frame state; returns the result item.
  function automatic decode_result_t decode_pulse_pair(pulse_pair_t p);
    decode_result_t r;
    logic [14:0]    mark;
    logic [14:0]    space;
    int             lo;
    int             hi;
    r     = '0;
    mark  = (p.lvl == c_active) ? p.d_first  : p.d_second;
    space = (p.lvl == c_active) ? p.d_second : p.d_first;
    // bounds are signed: a margin above nominal pushes the low bound negative
    lo    = int'(c_nominal) - int'(c_margin);
    hi    = int'(c_nominal) + int'(c_margin);
    if (space == '0) begin
      // end of frame: clean only on a byte boundary, even outside a frame
      if (bit_cnt == '0) begin
        r.ev  = EV_FRAME;
        r.len = byte_cnt;
      end else begin
        r.ev = EV_ERROR;
      end
      bit_cnt    = '0;
      byte_cnt   = '0;
      frame_open = 1'b0;
    end else if ((mark > c_hdr_mark && space < mark) ||
                 (space > c_hdr_space && mark < space)) begin
      // header: restart counting, keep the partial shift byte
      bit_cnt    = '0;
      byte_cnt   = '0;
      frame_open = 1'b1;
    end else if (int'(mark) < lo || int'(mark) > hi) begin
      // mark out of tolerance: leave the frame, keep the counts
      frame_open = 1'b0;
      r.ev       = EV_ERROR;
    end else if (frame_open) begin
      shift_reg = {(int'(space) >= 2 * int'(mark)), shift_reg[7:1]};
      bit_cnt   = bit_cnt + 3'd1;
      if (bit_cnt == '0) begin
        if (byte_cnt < c_max_bytes) begin
          r.ev     = EV_BYTE;
          r.val    = shift_reg;
          r.idx    = byte_cnt;
          byte_cnt = byte_cnt + 8'd1;
        end else begin
          // frame overflow: drop out, byte count stays put
          frame_open = 1'b0;
          r.ev       = EV_ERROR;
        end
      end
    end
    // data bit outside a frame: ignored, no event
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building blocks
  // ---------------------------------------------------------------------------

  task automatic push_raw(logic lvl, int d_first, int d_second);
    pulse_pair_t p;
    p.lvl      = lvl;
    p.d_first  = d_first[14:0];
    p.d_second = d_second[14:0];
    pairs_to_send.push_back(p);
    pairs_made++;
  endtask

  // Place mark and space in either half at random; the level follows.
  task automatic push_symbol(int mark, int space);
    if ($urandom_range(1)) push_raw(c_active, mark, space);
    else push_raw(!c_active, space, mark);
  endtask

  // Random duration, skewed toward small values so low bits vary too.
  function automatic int rand_dur();
    return $urandom_range(DUR_MAX) >> $urandom_range(14);
  endfunction

  task automatic push_noise();
    if ($urandom_range(1))
      push_raw(1'($urandom_range(1)), $urandom_range(DUR_MAX), $urandom_range(DUR_MAX));
    else push_raw(1'($urandom_range(1)), rand_dur(), rand_dur());
  endtask

  task automatic push_end();
    push_symbol(rand_dur(), 0);
  endtask

  // Pick the header form the current thresholds allow; fall back to noise.
  task automatic push_header();
    int mark;
    int space;
    int lo;
    if (c_hdr_mark < 15'h7FFF && ($urandom_range(1) || c_hdr_space == 15'h7FFF)) begin
      lo    = (int'(c_hdr_mark) + 1 < 2) ? 2 : int'(c_hdr_mark) + 1;
      mark  = $urandom_range((lo + 3000 > DUR_MAX) ? DUR_MAX : lo + 3000, lo);
      space = $urandom_range(mark - 1, 1);
      push_symbol(mark, space);
    end else if (c_hdr_space < 15'h7FFF) begin
      lo    = int'(c_hdr_space) + 1;
      space = $urandom_range((lo + 3000 > DUR_MAX) ? DUR_MAX : lo + 3000, lo);
      mark  = $urandom_range(space - 1, 0);
      push_symbol(mark, space);
    end else begin
      push_noise();
    end
  endtask

  // Data bit with a mark inside the tolerance window.
  task automatic push_bit(logic one);
    int lo;
    int hi;
    int mark;
    int space;
    lo = int'(c_nominal) - int'(c_margin);
    hi = int'(c_nominal) + int'(c_margin);
    if (lo < 1) lo = 1;
    if (hi > DUR_MAX) hi = DUR_MAX;
    mark = (lo > hi) ? 0 : $urandom_range(hi, lo);
    if (one || mark == 0) space = 2 * mark + $urandom_range(mark);
    else space = $urandom_range(2 * mark - 1, mark);
    if (space == 0) space = 1;
    if (space > DUR_MAX) space = DUR_MAX;
    // keep a one from reading as a space-type header where there is room
    if (one && mark > 0 && space > int'(c_hdr_space) && int'(c_hdr_space) >= 2 * mark)
      space = int'(c_hdr_space);
    push_symbol(mark, space);
  endtask

  // One frame: header, a few random bytes LSB first, then mostly a clean end.
  task automatic push_frame();
    int         n_bytes;
    int         cap;
    logic [7:0] data;
    if ($urandom_range(9) == 0) push_noise();
    push_header();
    cap     = int'(c_max_bytes) + 1;
    n_bytes = $urandom_range((cap > 6) ? 6 : cap);
    if ($urandom_range(29) == 0) n_bytes = (cap > 40) ? 40 : cap;
    for (int b = 0; b < n_bytes; b++) begin
      data = 8'($urandom_range(255));
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(59) == 0) push_noise();
        push_bit(data[k]);
      end
    end
    case ($urandom_range(9))
      0: begin
        // break off in mid-byte
        repeat ($urandom_range(7, 1)) push_bit(1'($urandom_range(1)));
        push_end();
      end
      1: ;
      default: push_end();
    endcase
  endtask

  task automatic push_random(int n);
    int target;
    target = pairs_made + n;
    while (pairs_made < target) push_frame();
  endtask

  task automatic write_reg(logic [2:0] index, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value[14:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_all(int act, int hm, int hs, int nom, int mrg, int maxb);
    write_reg(REG_ACTIVE_LEVEL, act);
    write_reg(REG_HEADER_MARK_MIN, hm);
    write_reg(REG_HEADER_SPACE_MIN, hs);
    write_reg(REG_BIT_MARK_NOMINAL, nom);
    write_reg(REG_BIT_MARGIN, mrg);
    write_reg(REG_MAX_FRAME_BYTES, maxb);
  endtask

  // Hold until every item went in and every result came back, plus pipeline slack.
  task automatic wait_drained();
    while (pairs_to_send.size() != 0 || s_tvalid || expected_events.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: present the head of the queue, hold it until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !pair_taken) begin
      // hold the offered item
    end else if (pairs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      s_tvalid <= 1'b1;
      s_tdata  <= {1'b0, pairs_to_send[0].d_second, pairs_to_send[0].d_first,
                   pairs_to_send[0].lvl};
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      m_tready      <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_stall_req != rx_stall_done) begin
      m_tready      <= 1'b0;
      rx_stall_left <= LONG_STALL;
      rx_stall_done <= rx_stall_done + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: track config writes and accepted pairs, check each result item
  // ---------------------------------------------------------------------------
  task automatic compare_field(string name, int want, int seen);
    if (want != seen) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, seen);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin : monitor
    decode_result_t seen;
    decode_result_t want;
    pulse_pair_t    got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else if (rst) begin
      clear_decoder();
      pair_taken <= 1'b0;
    end else begin
      if (cfg_we) apply_reg(cfg_index, cfg_wdata);
      pair_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        got.lvl      = s_tdata[0];
        got.d_first  = s_tdata[15:1];
        got.d_second = s_tdata[30:16];
        expected_events.push_back(decode_pulse_pair(got));
        void'(pairs_to_send.pop_front());
      end
      if (m_tvalid && m_tready) begin
        seen.ev  = m_tuser;
        seen.val = m_tdata[7:0];
        seen.idx = m_tdata[15:8];
        seen.len = m_tdata[23:16];
        if (expected_events.size() == 0) begin
          $error("result item with nothing expected: event_res %0d", seen.ev);
          n_fail++;
        end else begin
          want = expected_events.pop_front();
          compare_field("event_res", int'(want.ev), int'(seen.ev));
          compare_field("byte_value", int'(want.val), int'(seen.val));
          compare_field("byte_index", int'(want.idx), int'(seen.idx));
          compare_field("frame_length", int'(want.len), int'(seen.len));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_decoder();
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed: one-byte frame limit so overflow comes quickly
    write_reg(REG_MAX_FRAME_BYTES, 1);
    push_raw(1'b0, 0, 0);              // all-zero pair: clean end outside a frame
    push_bit(1'b1);                    // data bit outside a frame
    push_raw(1'b1, 9000, 4500);        // header by long mark
    repeat (8) push_bit(1'b1);         // byte 0xFF at index 0
    repeat (8) push_bit(1'b0);         // second byte overflows
    push_raw(1'b1, DUR_MAX, 0);        // end on a byte boundary, count kept after overflow
    push_raw(1'b0, 4500, 560);         // header by long space, space in first half
    repeat (3) push_bit(1'($urandom_range(1)));
    push_raw(1'b0, 0, 400);            // end in mid-byte
    push_raw(1'b1, 100, 300);          // mark below tolerance
    push_raw(1'b1, DUR_MAX, DUR_MAX);  // both halves at maximum: mark above tolerance
    wait_drained();

    // Nominal timing; sender idles a little, receiver a lot, with one long hold-off
    write_all(1, 2700, 1600, 400, 150, 19);
    send_idle_pct <= 11;
    recv_idle_pct <= 69;
    rx_stall_req  <= rx_stall_req + 1;
    push_random(250);
    wait_drained();
    // pause the sender until everything is back, then carry on
    push_random(250);
    wait_drained();

    // Inverted line, slower symbols, tiny frame limit; roles of the sides swap
    write_all(0, 9000, 4500, 1000, 300, 3);
    send_idle_pct <= 69;
    recv_idle_pct <= 11;
    push_random(500);
    wait_drained();

    // Extremes: largest frame limit and tolerance, mark headers impossible
    write_all(1, DUR_MAX, 0, 16383, 16383, 255);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    push_random(150);
    wait_drained();

    // Extremes: zero nominal with a wide margin, zero mark threshold, limit of one
    write_all(0, 0, DUR_MAX, 0, 16383, 1);
    push_random(150);
    wait_drained();

    // Short mixed-noise tail at zero thresholds and tolerance, frame limit of one
    write_all(1, 0, 0, 0, 0, 1);
    repeat (50) push_noise();
    wait_drained();

    if (n_fail == 0 && expected_events.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (expected_events.size() != 0)
        $error("%0d expected result items never arrived", expected_events.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
